### sv/cfr_pkg.sv
// shared types and codes of the chunked frame reassembler
package cfr_pkg;

    localparam int HDR_KEPT = 10;
    localparam int LEN_W    = 18;

    localparam logic [3:0] ST_TAKEN       = 4'd0;
    localparam logic [3:0] ST_MALFORMED   = 4'd1;
    localparam logic [3:0] ST_STALE       = 4'd2;
    localparam logic [3:0] ST_DUPLICATE   = 4'd3;
    localparam logic [3:0] ST_COUNT_RESET = 4'd4;
    localparam logic [3:0] ST_SIZE_RESET  = 4'd5;
    localparam logic [3:0] ST_STORED      = 4'd6;
    localparam logic [3:0] ST_COMPLETE    = 4'd7;
    localparam logic [3:0] ST_BUSY        = 4'd8;
    localparam logic [3:0] ST_READ        = 4'd9;
    localparam logic [3:0] ST_EMPTY       = 4'd10;

    localparam logic CMD_JUDGE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic              ver_ok;
        logic [15:0]       idx;
        logic [15:0]       cnt;
        logic [31:0]       id;
        logic [LEN_W-1:0]  len;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  frame_byte;
        logic        frame_last;
        logic [16:0] frame_length;
    } res_t;

endpackage

### sv/chunked_frame_reassembler.sv
// top level of the chunked frame reassembler
//
// one command channel: an item is taken at a rising edge with start high and
// busy low. req_type 0 carries one datagram byte (data_byte, end_of_datagram),
// req_type 1 asks for the next byte of a finished frame.
// every item gives exactly one result, shown for one cycle with done high;
// the receiver cannot stall, so there is no backpressure on results.
// datagram bytes other than the last: one per cycle while busy is low, result (taken)
// in the cycle after the beat; the payload goes straight into the spare slot.
// last byte of a datagram: goes through the command queue to the judge;
// busy through the judge state, and the swap state too when the chunk is
// committed (slot map read and swap), result on the cycle busy falls.
// read request: busy through the readout states, which stop early when no
// frame waits; each empty or used-up chunk that the readout steps over adds a
// chunk length ram read, result on the cycle busy falls.
// reset: assembly cleared, slot map identity with the last slot spare,
// no frame pending; the map valid bits replace a clearing pass, so items
// are taken right after reset.
module chunked_frame_reassembler #(
    parameter int MAX_CHUNKS   = 64,
    parameter int CHUNK_BYTES  = 1024,
    parameter int FRAME_BYTES  = 65536,
    parameter int HEADER_BYTES = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [7:0]  data_byte,
    input  logic        end_of_datagram,
    output logic        done,
    output logic [3:0]  status,
    output logic [7:0]  frame_byte,
    output logic        frame_last,
    output logic [16:0] frame_length
);

    // slot numbers run 0..MAX_CHUNKS, payload store holds one extra slot
    localparam int SW  = $clog2(MAX_CHUNKS + 1);
    localparam int PAW = $clog2(longint'(MAX_CHUNKS + 1) * longint'(CHUNK_BYTES));

    logic           accept;
    logic           back_busy, fifo_empty, cmd_push, cmd_pop;
    cfr_pkg::cmd_t  cmd_in, cmd_out;
    logic [SW-1:0]  spare_slot;
    logic           pay_we;
    logic [PAW-1:0] pay_waddr, pay_raddr;
    logic [7:0]     pay_wdata, pay_rdata;
    logic           f_valid, b_valid;
    cfr_pkg::res_t  f_res, b_res, out_res;

    // the judge and readout hold busy until their result is out
    assign busy   = back_busy || !fifo_empty;
    assign accept = start && !busy;

    cfr_front #(
        .M   (MAX_CHUNKS),
        .C   (CHUNK_BYTES),
        .H   (HEADER_BYTES),
        .SW  (SW),
        .PAW (PAW)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .req_type        (req_type),
        .data_byte       (data_byte),
        .end_of_datagram (end_of_datagram),
        .spare_slot      (spare_slot),
        .pay_we          (pay_we),
        .pay_waddr       (pay_waddr),
        .pay_wdata       (pay_wdata),
        .cmd_push        (cmd_push),
        .cmd             (cmd_in),
        .res_valid       (f_valid),
        .res             (f_res)
    );

    cfr_cmd_fifo u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .pop   (cmd_pop),
        .dout  (cmd_out),
        .empty (fifo_empty)
    );

    cfr_ram #(.WIDTH(8), .ADDR_W(PAW)) u_payload (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (pay_wdata),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    cfr_back #(
        .M   (MAX_CHUNKS),
        .C   (CHUNK_BYTES),
        .F   (FRAME_BYTES),
        .H   (HEADER_BYTES),
        .SW  (SW),
        .PAW (PAW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .fifo_out   (cmd_out),
        .pop        (cmd_pop),
        .busy       (back_busy),
        .spare_slot (spare_slot),
        .pay_raddr  (pay_raddr),
        .pay_rdata  (pay_rdata),
        .res_valid  (b_valid),
        .res        (b_res)
    );

    // the two result sources never fire in the same cycle
    assign out_res      = b_valid ? b_res : f_res;
    assign done         = f_valid || b_valid;
    assign status       = out_res.status;
    assign frame_byte   = out_res.frame_byte;
    assign frame_last   = out_res.frame_last;
    assign frame_length = out_res.frame_length;

endmodule

### sv/cfr_ram.sv
// generic single write port ram with registered read
module cfr_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [2**ADDR_W];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/cfr_cmd_fifo.sv
// two entry command queue between intake and execution
module cfr_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cfr_pkg::cmd_t din,
    input  logic          pop,
    output cfr_pkg::cmd_t dout,
    output logic          empty
);

    cfr_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = entry_reg[rd_ptr_reg];
    assign empty = (cnt_reg == 2'd0);

endmodule

### sv/cfr_front.sv
// intake: header capture, payload staging into the spare slot, command issue
module cfr_front #(
    parameter int M   = 64,
    parameter int C   = 1024,
    parameter int H   = 10,
    parameter int SW  = 7,
    parameter int PAW = 17
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic           req_type,
    input  logic [7:0]     data_byte,
    input  logic           end_of_datagram,
    input  logic [SW-1:0]  spare_slot,
    output logic           pay_we,
    output logic [PAW-1:0] pay_waddr,
    output logic [7:0]     pay_wdata,
    output logic           cmd_push,
    output cfr_pkg::cmd_t  cmd,
    output logic           res_valid,
    output cfr_pkg::res_t  res
);

    localparam int POS_CAP = H + C + 1;
    localparam int LW      = $clog2(POS_CAP + 1);
    localparam int OW      = (C > 1) ? $clog2(C) : 1;

    logic [LW-1:0] pos_reg, pos_next;
    logic [7:0]    hdr_reg [cfr_pkg::HDR_KEPT];
    logic          res_valid_reg, res_valid_next;
    logic          is_hdr, in_pay, dg_byte;
    logic [OW-1:0] pay_off;
    logic [7:0]    hdr_last;

    always_comb
    begin
        dg_byte  = accept && !req_type;
        is_hdr   = pos_reg < LW'(cfr_pkg::HDR_KEPT);
        in_pay   = (pos_reg >= LW'(H)) && ((pos_reg - LW'(H)) < LW'(C));
        pay_off  = OW'(pos_reg - LW'(H));

        // a datagram with no payload ends on the last id byte, still in flight
        hdr_last = (pos_reg == LW'(cfr_pkg::HDR_KEPT - 1)) ? data_byte
                                                           : hdr_reg[cfr_pkg::HDR_KEPT - 1];

        pay_we    = dg_byte && in_pay;
        pay_waddr = PAW'(spare_slot) * PAW'(C) + PAW'(pay_off);
        pay_wdata = data_byte;

        cmd_push   = accept && (req_type || end_of_datagram);
        cmd.kind   = req_type ? cfr_pkg::CMD_READ : cfr_pkg::CMD_JUDGE;
        cmd.ver_ok = (hdr_reg[0] == 8'd1);
        cmd.idx    = {hdr_reg[2], hdr_reg[3]};
        cmd.cnt    = {hdr_reg[4], hdr_reg[5]};
        cmd.id     = {hdr_reg[6], hdr_reg[7], hdr_reg[8], hdr_last};
        cmd.len    = cfr_pkg::LEN_W'(pos_reg) + cfr_pkg::LEN_W'(1);

        pos_next = pos_reg;
        if (dg_byte)
        begin
            if (end_of_datagram)
            begin
                pos_next = '0;
            end
            else if (pos_reg < LW'(POS_CAP))
            begin
                pos_next = pos_reg + LW'(1);
            end
        end

        res_valid_next = dg_byte && !end_of_datagram;
        res            = '0;
        res.status     = cfr_pkg::ST_TAKEN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dg_byte && is_hdr)
        begin
            hdr_reg[pos_reg[3:0]] <= data_byte;
        end
    end

    assign res_valid = res_valid_reg;

endmodule

### sv/cfr_back.sv
// execution: datagram judgement, slot map commit and frame readout
module cfr_back #(
    parameter int M   = 64,
    parameter int C   = 1024,
    parameter int F   = 65536,
    parameter int H   = 10,
    parameter int SW  = 7,
    parameter int PAW = 17
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fifo_empty,
    input  cfr_pkg::cmd_t  fifo_out,
    output logic           pop,
    output logic           busy,
    output logic [SW-1:0]  spare_slot,
    output logic [PAW-1:0] pay_raddr,
    input  logic [7:0]     pay_rdata,
    output logic           res_valid,
    output cfr_pkg::res_t  res
);

    localparam int IW = (M > 1) ? $clog2(M) : 1;
    localparam int CW = $clog2(M + 1);
    localparam int PW = $clog2(C + 1);
    localparam int BW = $clog2(F + 1);
    localparam int LN = cfr_pkg::LEN_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_J1   = 3'd1;
    localparam logic [2:0] S_J2   = 3'd2;
    localparam logic [2:0] S_R0   = 3'd3;
    localparam logic [2:0] S_R1   = 3'd4;
    localparam logic [2:0] S_R2   = 3'd5;

    logic [2:0]    state_reg, state_next;
    cfr_pkg::cmd_t cmd_reg, cmd_next;
    logic          active_reg, active_next;
    logic [31:0]   cur_id_reg, cur_id_next;
    logic [CW-1:0] exp_reg, exp_next;
    logic [CW-1:0] held_reg, held_next;
    logic [BW-1:0] bytes_reg, bytes_next;
    logic [M-1:0]  present_reg, present_next;
    logic [M-1:0]  map_valid_reg, map_valid_next;
    logic [SW-1:0] spare_reg, spare_next;
    logic          ready_reg, ready_next;
    logic [CW-1:0] rc_reg, rc_next;
    logic [PW-1:0] ro_reg, ro_next;
    cfr_pkg::res_t res_reg, res_next;
    logic          res_valid_reg, res_valid_next;

    logic          slot_we, clen_we;
    logic [IW-1:0] slot_raddr;
    logic [SW-1:0] slot_rdata, slot_cur, slot_old;
    logic [PW-1:0] clen_rdata;
    logic [IW-1:0] idx_i, rc_i;
    logic [LN-1:0] pay;
    logic          hdr_bad, restart, stale, cmis, dup, over, last_chunk;
    logic [BW-1:0] eff_bytes, new_bytes;
    logic [CW-1:0] eff_held;

    cfr_ram #(.WIDTH(SW), .ADDR_W(IW)) u_slot_map (
        .clk   (clk),
        .we    (slot_we),
        .waddr (idx_i),
        .wdata (spare_reg),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    cfr_ram #(.WIDTH(PW), .ADDR_W(IW)) u_chunk_len (
        .clk   (clk),
        .we    (clen_we),
        .waddr (idx_i),
        .wdata (PW'(pay)),
        .raddr (rc_i),
        .rdata (clen_rdata)
    );

    always_comb
    begin
        idx_i = cmd_reg.idx[IW-1:0];
        rc_i  = rc_reg[IW-1:0];
        pay   = cmd_reg.len - LN'(H);

        hdr_bad = (cmd_reg.len < LN'(H)) || !cmd_reg.ver_ok || (cmd_reg.cnt == 16'd0) ||
                  (cmd_reg.cnt > 16'(M)) || (cmd_reg.idx >= cmd_reg.cnt) || (pay > LN'(C));
        restart = !active_reg || (cmd_reg.id > cur_id_reg);
        stale   = !restart && (cmd_reg.id < cur_id_reg);
        cmis    = !restart && (CW'(cmd_reg.cnt) != exp_reg);
        dup     = !restart && present_reg[idx_i];

        eff_bytes  = restart ? '0 : bytes_reg;
        eff_held   = restart ? '0 : held_reg;
        over       = (32'(eff_bytes) > 32'(F)) || ((32'(eff_bytes) + 32'(pay)) > 32'(F));
        new_bytes  = BW'(32'(eff_bytes) + 32'(pay));
        last_chunk = (eff_held + CW'(1)) == CW'(cmd_reg.cnt);

        slot_old = map_valid_reg[idx_i] ? slot_rdata : SW'(idx_i);
        slot_cur = map_valid_reg[rc_i] ? slot_rdata : SW'(rc_i);

        state_next     = state_reg;
        cmd_next       = cmd_reg;
        active_next    = active_reg;
        cur_id_next    = cur_id_reg;
        exp_next       = exp_reg;
        held_next      = held_reg;
        bytes_next     = bytes_reg;
        present_next   = present_reg;
        map_valid_next = map_valid_reg;
        spare_next     = spare_reg;
        ready_next     = ready_reg;
        rc_next        = rc_reg;
        ro_next        = ro_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;
        pop            = 1'b0;
        slot_we        = 1'b0;
        clen_we        = 1'b0;
        slot_raddr     = idx_i;
        pay_raddr      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!fifo_empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = fifo_out;
                    state_next = (fifo_out.kind == cfr_pkg::CMD_READ) ? S_R0 : S_J1;
                end
            end
            S_J1:
            begin
                res_next   = '0;
                state_next = S_IDLE;
                if (ready_reg)
                begin
                    res_next.status = cfr_pkg::ST_BUSY;
                    res_valid_next  = 1'b1;
                end
                else if (hdr_bad)
                begin
                    res_next.status = cfr_pkg::ST_MALFORMED;
                    res_valid_next  = 1'b1;
                end
                else if (stale)
                begin
                    res_next.status = cfr_pkg::ST_STALE;
                    res_valid_next  = 1'b1;
                end
                else if (cmis)
                begin
                    active_next     = 1'b0;
                    cur_id_next     = '0;
                    exp_next        = '0;
                    held_next       = '0;
                    bytes_next      = '0;
                    present_next    = '0;
                    res_next.status = cfr_pkg::ST_COUNT_RESET;
                    res_valid_next  = 1'b1;
                end
                else
                begin
                    // a newer frame or an idle assembler starts over
                    if (restart)
                    begin
                        active_next  = 1'b1;
                        cur_id_next  = cmd_reg.id;
                        exp_next     = CW'(cmd_reg.cnt);
                        held_next    = '0;
                        bytes_next   = '0;
                        present_next = '0;
                    end
                    if (dup)
                    begin
                        res_next.status = cfr_pkg::ST_DUPLICATE;
                        res_valid_next  = 1'b1;
                    end
                    else if (over)
                    begin
                        active_next     = 1'b0;
                        cur_id_next     = '0;
                        exp_next        = '0;
                        held_next       = '0;
                        bytes_next      = '0;
                        present_next    = '0;
                        res_next.status = cfr_pkg::ST_SIZE_RESET;
                        res_valid_next  = 1'b1;
                    end
                    else
                    begin
                        clen_we             = 1'b1;
                        present_next[idx_i] = 1'b1;
                        held_next           = eff_held + CW'(1);
                        bytes_next          = new_bytes;
                        state_next          = S_J2;
                        res_next.status     = cfr_pkg::ST_STORED;
                        if (last_chunk)
                        begin
                            res_next.status       = cfr_pkg::ST_COMPLETE;
                            res_next.frame_length = 17'(new_bytes);
                            active_next           = 1'b0;
                            if (new_bytes != '0)
                            begin
                                ready_next = 1'b1;
                                rc_next    = '0;
                                ro_next    = '0;
                            end
                        end
                    end
                end
            end
            S_J2:
            begin
                // swap the staged slot into the map, old slot becomes the spare
                slot_we              = 1'b1;
                map_valid_next[idx_i] = 1'b1;
                spare_next           = slot_old;
                res_valid_next       = 1'b1;
                state_next           = S_IDLE;
            end
            S_R0:
            begin
                slot_raddr = rc_i;
                if (!ready_reg)
                begin
                    res_next        = '0;
                    res_next.status = cfr_pkg::ST_EMPTY;
                    res_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
                else if ((rc_reg >= exp_reg) || (bytes_reg == '0))
                begin
                    ready_next      = 1'b0;
                    res_next        = '0;
                    res_next.status = cfr_pkg::ST_EMPTY;
                    res_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    state_next = S_R1;
                end
            end
            S_R1:
            begin
                slot_raddr = rc_i;
                if (ro_reg >= clen_rdata)
                begin
                    // chunk used up or empty, move on
                    rc_next    = rc_reg + CW'(1);
                    ro_next    = '0;
                    state_next = S_R0;
                end
                else
                begin
                    pay_raddr  = PAW'(slot_cur) * PAW'(C) + PAW'(ro_reg);
                    state_next = S_R2;
                end
            end
            S_R2:
            begin
                res_next            = '0;
                res_next.status     = cfr_pkg::ST_READ;
                res_next.frame_byte = pay_rdata;
                ro_next             = ro_reg + PW'(1);
                bytes_next          = bytes_reg - BW'(1);
                if (bytes_reg == BW'(1))
                begin
                    res_next.frame_last = 1'b1;
                    ready_next          = 1'b0;
                end
                res_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= 1'b0;
            cur_id_reg    <= '0;
            exp_reg       <= '0;
            held_reg      <= '0;
            bytes_reg     <= '0;
            present_reg   <= '0;
            map_valid_reg <= '0;
            spare_reg     <= SW'(M);
            ready_reg     <= 1'b0;
            rc_reg        <= '0;
            ro_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            cur_id_reg    <= cur_id_next;
            exp_reg       <= exp_next;
            held_reg      <= held_next;
            bytes_reg     <= bytes_next;
            present_reg   <= present_next;
            map_valid_reg <= map_valid_next;
            spare_reg     <= spare_next;
            ready_reg     <= ready_next;
            rc_reg        <= rc_next;
            ro_reg        <= ro_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign spare_slot = spare_reg;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

endmodule

### sv/cfr_checker.sv
// port level checks of the chunked frame reassembler and their binding
module cfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        req_type,
    input logic [7:0]  data_byte,
    input logic        end_of_datagram,
    input logic        done,
    input logic [3:0]  status,
    input logic [7:0]  frame_byte,
    input logic        frame_last,
    input logic [16:0] frame_length
);

    // a taken result answers a non-final datagram beat of the cycle before
    a_taken_follows_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == cfr_pkg::ST_TAKEN) |->
        $past(start && !busy && !req_type && !end_of_datagram))
        else $error("taken result without a matching beat");

    // a final byte or a read request holds off the next beat
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req_type || end_of_datagram) |=> busy)
        else $error("busy not raised after a command beat");

    // byte and last flag only come with a read
    a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != cfr_pkg::ST_READ) |-> (frame_byte == 8'd0) && !frame_last)
        else $error("frame byte outside a read result");

    // length only comes with a complete
    a_length_field: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != cfr_pkg::ST_COMPLETE) |-> (frame_length == 17'd0))
        else $error("frame length outside a complete result");

endmodule

bind chunked_frame_reassembler cfr_checker u_cfr_checker (.*);
